// ===== rtl/wheel_encoder_odometry_unwrap_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef WHEEL_ENCODER_ODOMETRY_UNWRAP_MACROS_SVH
`define WHEEL_ENCODER_ODOMETRY_UNWRAP_MACROS_SVH

// a condition that holds at every clock edge outside reset
`define WEOU_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// a trigger that implies a condition at the next clock edge
`define WEOU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/weou_pkg.sv =====
package weou_pkg;

	localparam int RAW_W          = 16;
	localparam int SPAN_W         = 17;
	localparam int WRAP_W         = 32;
	localparam int PROD_W         = WRAP_W + SPAN_W + 1;
	localparam int OUT_W          = 48;
	localparam int ACCUM_WIDTH_DEF = 48;
	localparam int NEAR_LIMIT     = 4;
	localparam int CFG_DATA_W     = 17;
	localparam int CFG_IDX_W      = 2;

	localparam logic signed [RAW_W-1:0] LOW_LIMIT_RST  = -16'sd19661;
	localparam logic signed [RAW_W-1:0] HIGH_LIMIT_RST = 16'sd19660;
	localparam logic [SPAN_W-1:0]       SPAN_RST       = 17'd65535;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW  = 2'd0,
		CFG_HIGH = 2'd1,
		CFG_SPAN = 2'd2
	} weou_cfg_e;

	typedef struct packed {
		logic signed [RAW_W-1:0] right_raw;
		logic signed [RAW_W-1:0] left_raw;
		logic                    gap_seen;
	} weou_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left_odometry;
		logic signed [OUT_W-1:0] right_odometry;
	} weou_out_t;

	// stage advance strobes shared by the datapath modules
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
	} weou_ctrl_t;

endpackage

// ===== rtl/weou_unwrap.sv =====
module weou_unwrap import weou_pkg::*; #(
	parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  weou_ctrl_t                    ctrl,
	input  logic signed [RAW_W-1:0]       raw,
	input  logic signed [RAW_W-1:0]       low_limit,
	input  logic signed [RAW_W-1:0]       high_limit,
	input  logic [SPAN_W-1:0]             span,
	output logic [ACCUM_WIDTH-1:0]        pos,
	output logic                          near
);

	logic signed [RAW_W-1:0]  prev_raw_q;
	logic signed [WRAP_W-1:0] mult_q;
	logic signed [WRAP_W-1:0] mult_d;
	logic signed [SPAN_W:0]   span_ext;
	logic signed [PROD_W-1:0] prod;
	logic [ACCUM_WIDTH-1:0]   pos_d;
	logic [ACCUM_WIDTH-1:0]   pos_s2;
	logic                     fwd_wrap;
	logic                     bwd_wrap;

	// wrap detection against the previous raw reading
	assign fwd_wrap = (raw < low_limit) && (prev_raw_q > high_limit);
	assign bwd_wrap = (raw > high_limit) && (prev_raw_q < low_limit);

	always_comb begin
		mult_d = mult_q;
		if (fwd_wrap) begin
			mult_d = mult_q + 32'sd1;
		end else if (bwd_wrap) begin
			mult_d = mult_q - 32'sd1;
		end
	end

	// stage 1: multiplier and last raw reading, they also hold the item in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= '0;
			mult_q     <= '0;
		end else if (ctrl.adv_s1) begin
			prev_raw_q <= raw;
			mult_q     <= mult_d;
		end
	end

	// stage 2: unwrapped position = raw + multiplier * span
	assign span_ext = $signed({1'b0, span});
	assign prod     = mult_q * span_ext;
	assign pos_d    = ACCUM_WIDTH'(prev_raw_q) + ACCUM_WIDTH'(prod);

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			pos_s2 <= pos_d;
		end
	end

	// position within NEAR_LIMIT ticks of zero (-4 to 4), read as signed
	assign near = (pos_s2 <= ACCUM_WIDTH'(NEAR_LIMIT))
		|| (pos_s2 >= ~ACCUM_WIDTH'(NEAR_LIMIT - 1));
	assign pos  = pos_s2;

endmodule

// ===== rtl/weou_accum.sv =====
module weou_accum import weou_pkg::*; #(
	parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  weou_ctrl_t              ctrl,
	input  logic [ACCUM_WIDTH-1:0]  pos,
	input  logic                    hold,
	output logic signed [OUT_W-1:0] odometry
);

	logic [ACCUM_WIDTH-1:0] prev_q;
	logic [ACCUM_WIDTH-1:0] accum_q;

	// add the step since the last position unless this item holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			accum_q <= '0;
		end else if (ctrl.adv_s3) begin
			prev_q <= pos;
			if (!hold) begin
				accum_q <= accum_q + pos - prev_q;
			end
		end
	end

	assign odometry = OUT_W'(accum_q);

endmodule

// ===== rtl/wheel_encoder_odometry_unwrap.sv =====
// path: stage 1 wrap registers, stage 2 position register, then the output accumulators
// throughput: one transaction per cycle while out_ready is held high; the wrap multiplier
// update closes in stage 1 and the accumulator update closes in the output stage
// reset: arst_n clears the pipeline, wrap state and accumulators and
// restores the threshold and span registers to their defaults
`include "wheel_encoder_odometry_unwrap_macros.svh"

module wheel_encoder_odometry_unwrap import weou_pkg::*; #(
	parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  weou_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output weou_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [RAW_W-1:0] low_limit_q;
	logic signed [RAW_W-1:0] high_limit_q;
	logic [SPAN_W-1:0]       span_q;

	logic                    v_s1;
	logic                    v_s2;
	logic                    out_valid_q;
	logic                    gap_s1;
	logic                    gap_s2;
	logic                    first_q;
	logic                    ready_s2;
	logic                    ready_s3;
	logic                    hold;
	logic                    near_l;
	logic                    near_r;
	logic [ACCUM_WIDTH-1:0]  pos_l;
	logic [ACCUM_WIDTH-1:0]  pos_r;
	weou_ctrl_t              ctrl;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RST;
			high_limit_q <= HIGH_LIMIT_RST;
			span_q       <= SPAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOW:  low_limit_q  <= $signed(cfg_data[RAW_W-1:0]);
				CFG_HIGH: high_limit_q <= $signed(cfg_data[RAW_W-1:0]);
				CFG_SPAN: span_q       <= cfg_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control, each stage fills when the next one frees
	assign ready_s3    = !out_valid_q || out_ready;
	assign ready_s2    = !v_s2 || ready_s3;
	assign in_ready    = !v_s1 || ready_s2;
	assign ctrl.adv_s1 = in_valid && in_ready;
	assign ctrl.adv_s2 = v_s1 && ready_s2;
	assign ctrl.adv_s3 = v_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			first_q     <= 1'b1;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				out_valid_q <= v_s2;
			end
			if (ctrl.adv_s3) begin
				first_q <= 1'b0;
			end
		end
	end

	// gap flag travels beside the positions
	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			gap_s1 <= in_data.gap_seen;
		end
		if (ctrl.adv_s2) begin
			gap_s2 <= gap_s1;
		end
	end

	weou_unwrap #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_unwrap_r (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.raw        (in_data.right_raw),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.span       (span_q),
		.pos        (pos_r),
		.near       (near_r)
	);

	weou_unwrap #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_unwrap_l (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.raw        (in_data.left_raw),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.span       (span_q),
		.pos        (pos_l),
		.near       (near_l)
	);

	// first item after reset, or a gap-flagged item with both positions near zero, adds nothing
	assign hold = first_q || (gap_s2 && near_l && near_r);

	weou_accum #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_accum_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.pos      (pos_l),
		.hold     (hold),
		.odometry (out_data.left_odometry)
	);

	weou_accum #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_accum_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.pos      (pos_r),
		.hold     (hold),
		.odometry (out_data.right_odometry)
	);

	assign out_valid = out_valid_q;

	// checks
	`WEOU_ASSERT(a_ready_when_empty, out_valid || in_ready, "input stalled with empty output")
	`WEOU_ASSERT_NEXT(a_result_follows, ctrl.adv_s3, out_valid, "stage 2 transaction lost")
	`WEOU_ASSERT_NEXT(a_first_zero, first_q && ctrl.adv_s3,
		out_data.left_odometry == '0 && out_data.right_odometry == '0,
		"first result after reset not zero")

endmodule
